// ===== hw/rtl/lpe_pkg.sv =====
// Shared constants and types for the LED pixel pulse encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package lpe_pkg;

  localparam int LPE_LED_COUNT     = 16;
  localparam int LPE_INDICATOR_MIN = 16;

  localparam int BITS_PER_LED = 24;
  localparam int CNT_W        = 5;
  localparam int SLOT_W       = 9;
  localparam int CH_W         = 8;

  localparam logic [7:0] CFG_RGB_BRIGHTNESS       = 8'd0;
  localparam logic [7:0] CFG_INDICATOR_BRIGHTNESS = 8'd1;
  localparam logic [7:0] CFG_ONE_TIME             = 8'd2;
  localparam logic [7:0] CFG_ZERO_TIME            = 8'd3;

  localparam logic [7:0] RST_RGB_BRIGHTNESS       = 8'd255;
  localparam logic [7:0] RST_INDICATOR_BRIGHTNESS = 8'd255;
  localparam logic [7:0] RST_ONE_TIME             = 8'd51;
  localparam logic [7:0] RST_ZERO_TIME            = 8'd21;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/led_pixel_pulse_encoder_unit.sv =====
// Top level of the LED pixel pulse encoder; holds the configuration
// registers and the input stages. Depends on lpe_pkg, lpe_lane, lpe_serializer.
`default_nettype none
// A pixel word (LED index, red, green, blue) passes through two stages in
// which three lanes scale the colors in parallel, and then leaves as 24
// pulse words, one per cycle while out_stall is low, green first and MSB
// first. The output serializer sets the rate: it sends one pixel at a time,
// with the next pixels taken in and scaled while the current one is still
// being sent. A pixel whose index is at or above LED_COUNT is taken and
// dropped without output.
// Configuration writes are always ready and must happen only while idle.
module led_pixel_pulse_encoder_unit #(
  parameter int LED_COUNT     = lpe_pkg::LPE_LED_COUNT,
  parameter int INDICATOR_MIN = lpe_pkg::LPE_INDICATOR_MIN
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_led_index,
  input  wire logic [7:0]                 in_red,
  input  wire logic [7:0]                 in_green,
  input  wire logic [7:0]                 in_blue,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [lpe_pkg::SLOT_W-1:0] out_slot_address,
  output logic      [7:0]                 out_high_time,
  output logic                            out_last_word,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [7:0]                 cfg_index,
  input  wire logic [7:0]                 cfg_data
);
  import lpe_pkg::*;

  logic [7:0] rgb_br_r, ind_br_r, one_time_r, zero_time_r;

  logic              s1_v_r, s2_v_r;
  logic [SLOT_W-1:0] s1_slot_r, s2_slot_r;
  logic [7:0]        bright;
  logic [7:0]        ind_eff;
  logic              in_range;
  logic              in_acc;
  logic              pix_take;
  logic              s2_free, s1_free;
  lane_ctl_t         ctl;
  logic [CH_W-1:0]   sc_r, sc_g, sc_b;
  logic [SLOT_W-1:0] base_slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_br_r    <= RST_RGB_BRIGHTNESS;
      ind_br_r    <= RST_INDICATOR_BRIGHTNESS;
      one_time_r  <= RST_ONE_TIME;
      zero_time_r <= RST_ZERO_TIME;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RGB_BRIGHTNESS:       rgb_br_r    <= cfg_data;
        CFG_INDICATOR_BRIGHTNESS: ind_br_r    <= cfg_data;
        CFG_ONE_TIME:             one_time_r  <= cfg_data;
        CFG_ZERO_TIME:            zero_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s2_free  = !s2_v_r || pix_take;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;

  assign in_range = {1'b0, in_led_index} < 9'(LED_COUNT);
  assign ind_eff  = (ind_br_r < 8'(INDICATOR_MIN)) ? 8'(INDICATOR_MIN) : ind_br_r;
  assign bright   = ((LED_COUNT > 1) && (in_led_index == 8'd0)) ? ind_eff : rgb_br_r;
  assign base_slot = SLOT_W'({1'b0, in_led_index} << 4) + SLOT_W'({1'b0, in_led_index} << 3);

  assign ctl.s1_en = in_acc;
  assign ctl.s2_en = s1_v_r && s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_valid && in_range;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      s1_slot_r <= base_slot;
    end
    if (ctl.s2_en) begin
      s2_slot_r <= s1_slot_r;
    end
  end

  lpe_lane u_lane_r (
    .clk    (clk),
    .ctl    (ctl),
    .color  (in_red),
    .bright (bright),
    .scaled (sc_r)
  );

  lpe_lane u_lane_g (
    .clk    (clk),
    .ctl    (ctl),
    .color  (in_green),
    .bright (bright),
    .scaled (sc_g)
  );

  lpe_lane u_lane_b (
    .clk    (clk),
    .ctl    (ctl),
    .color  (in_blue),
    .bright (bright),
    .scaled (sc_b)
  );

  lpe_serializer u_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_valid        (s2_v_r),
    .green            (sc_g),
    .red              (sc_r),
    .blue             (sc_b),
    .base_slot        (s2_slot_r),
    .one_time         (one_time_r),
    .zero_time        (zero_time_r),
    .pix_take         (pix_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot_address (out_slot_address),
    .out_high_time    (out_high_time),
    .out_last_word    (out_last_word)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/lpe_lane.sv =====
// One color lane: registered 8x8 product, then floor(product / 255).
// Depends on lpe_pkg for the lane control struct and widths.
`default_nettype none
module lpe_lane (
  input  wire logic                    clk,
  input  wire lpe_pkg::lane_ctl_t      ctl,
  input  wire logic [lpe_pkg::CH_W-1:0] color,
  input  wire logic [lpe_pkg::CH_W-1:0] bright,
  output logic      [lpe_pkg::CH_W-1:0] scaled
);
  import lpe_pkg::*;

  logic [2*CH_W-1:0] prod_r;
  logic [CH_W-1:0]   scaled_r;
  logic [2*CH_W:0]   sum;
  logic [CH_W:0]     q_est;
  logic [2*CH_W:0]   rem;
  logic [CH_W:0]     q_fix;

  // The estimate (p + p/256) / 256 is never above the true quotient and
  // at most one below it, so a single compare finishes the division.
  always_comb begin
    sum   = {1'b0, prod_r} + {{(CH_W+1){1'b0}}, prod_r[2*CH_W-1:CH_W]};
    q_est = sum[2*CH_W:CH_W];
    rem   = {1'b0, prod_r} - {q_est, {CH_W{1'b0}}} + {{CH_W{1'b0}}, q_est};
    q_fix = (rem >= (2*CH_W+1)'(255)) ? q_est + (CH_W+1)'(1) : q_est;
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      prod_r <= color * bright;
    end
    if (ctl.s2_en) begin
      scaled_r <= q_fix[CH_W-1:0];
    end
  end

  assign scaled = scaled_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lpe_serializer.sv =====
// Merge stage: joins the three lane results into one GRB pixel and sends
// it as 24 pulse words, MSB first. Depends on lpe_pkg.
`default_nettype none
module lpe_serializer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        pix_valid,
  input  wire logic [lpe_pkg::CH_W-1:0]    green,
  input  wire logic [lpe_pkg::CH_W-1:0]    red,
  input  wire logic [lpe_pkg::CH_W-1:0]    blue,
  input  wire logic [lpe_pkg::SLOT_W-1:0]  base_slot,
  input  wire logic [7:0]                  one_time,
  input  wire logic [7:0]                  zero_time,
  output logic                             pix_take,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [lpe_pkg::SLOT_W-1:0]  out_slot_address,
  output logic      [7:0]                  out_high_time,
  output logic                             out_last_word
);
  import lpe_pkg::*;

  logic                    busy_r, busy_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [BITS_PER_LED-1:0] word_r;
  logic [SLOT_W-1:0]       slot_r;
  logic                    last;
  logic                    done;

  assign last     = (cnt_r == CNT_W'(BITS_PER_LED - 1));
  assign done     = busy_r && last && !out_stall;
  assign pix_take = pix_valid && (!busy_r || done);

  always_comb begin
    busy_nxt = busy_r;
    if (pix_take) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      word_r <= {green, red, blue};
      slot_r <= base_slot;
      cnt_r  <= '0;
    end else if (busy_r && !out_stall) begin
      word_r <= {word_r[BITS_PER_LED-2:0], 1'b0};
      slot_r <= slot_r + SLOT_W'(1);
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  assign out_valid        = busy_r;
  assign out_slot_address = slot_r;
  assign out_high_time    = word_r[BITS_PER_LED-1] ? one_time : zero_time;
  assign out_last_word    = last;

endmodule
`default_nettype wire

// ===== verif/lpe_sb_pkg.sv =====
// Scoreboard for the LED pixel pulse encoder testbench: predicts the 24 pulse
// words of every in-range pixel word and checks the words leaving the block.
// Depends on lpe_pkg for widths, register indexes and reset values.
package lpe_sb_pkg;
  import lpe_pkg::*;

  localparam logic [15:0] FULL_SCALE = 16'd255;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_address;
    logic [7:0]        high_time;
    logic              last_word;
  } pulse_word_t;

  class grb_word_checker;
    logic [7:0]  rgb_brightness;
    logic [7:0]  indicator_brightness;
    logic [7:0]  one_time;
    logic [7:0]  zero_time;
    pulse_word_t due_words[$];
    int          errors;
    int          pixels;
    int          dropped;
    int          words_checked;

    function new();
      rgb_brightness       = RST_RGB_BRIGHTNESS;
      indicator_brightness = RST_INDICATOR_BRIGHTNESS;
      one_time             = RST_ONE_TIME;
      zero_time            = RST_ZERO_TIME;
      errors               = 0;
      pixels               = 0;
      dropped              = 0;
      words_checked        = 0;
    endfunction

    function void note_reg_write(logic [7:0] index, logic [7:0] data);
      case (index)
        CFG_RGB_BRIGHTNESS:       rgb_brightness = data;
        CFG_INDICATOR_BRIGHTNESS: indicator_brightness = data;
        CFG_ONE_TIME:             one_time = data;
        CFG_ZERO_TIME:            zero_time = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] scale_level(logic [7:0] level, logic [7:0] br);
      logic [15:0] product;
      logic [15:0] quotient;
      product  = level * br;
      quotient = product / FULL_SCALE;
      return quotient[7:0];
    endfunction

    function void note_pixel(logic [7:0] led_index, logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue);
      logic [7:0]  br;
      logic [23:0] grb;
      logic [31:0] slot;
      pulse_word_t w;
      pixels++;
      if (int'(led_index) >= LPE_LED_COUNT) begin
        dropped++;
        return;
      end
      if (LPE_LED_COUNT > 1 && led_index == 8'd0) begin
        br = (int'(indicator_brightness) < LPE_INDICATOR_MIN) ?
             8'(LPE_INDICATOR_MIN) : indicator_brightness;
      end else begin
        br = rgb_brightness;
      end
      grb = {scale_level(green, br), scale_level(red, br), scale_level(blue, br)};
      for (int k = 0; k < BITS_PER_LED; k++) begin
        slot           = int'(led_index) * BITS_PER_LED + k;
        w.slot_address = slot[SLOT_W-1:0];
        w.high_time    = grb[BITS_PER_LED-1-k] ? one_time : zero_time;
        w.last_word    = (k == BITS_PER_LED - 1);
        due_words.push_back(w);
      end
    endfunction

    function void check_word(logic [SLOT_W-1:0] slot_address, logic [7:0] high_time,
                             logic last_word);
      pulse_word_t want;
      if (due_words.size() == 0) begin
        $error("Unexpected pulse word: slot_address %0d, high_time %0d, last_word %0b",
               slot_address, high_time, last_word);
        errors++;
        return;
      end
      want = due_words.pop_front();
      words_checked++;
      if (slot_address !== want.slot_address) begin
        $error("slot_address: expected %0d, actual %0d", want.slot_address, slot_address);
        errors++;
      end
      if (high_time !== want.high_time) begin
        $error("high_time: expected %0d, actual %0d", want.high_time, high_time);
        errors++;
      end
      if (last_word !== want.last_word) begin
        $error("last_word: expected %0b, actual %0b", want.last_word, last_word);
        errors++;
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_led_pixel_pulse_encoder_unit.sv =====
// Top of the LED pixel pulse encoder testbench: drives pixel words and
// register writes, stalls the output and checks every pulse word.
// Depends on lpe_pkg, lpe_sb_pkg and the led_pixel_pulse_encoder_unit RTL.
module tb_led_pixel_pulse_encoder_unit;
  import lpe_pkg::*;
  import lpe_sb_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 40;

  typedef enum int {RX_NONE, RX_LIGHT, RX_HEAVY, RX_PERIODIC, RX_LONG} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_led_index;
  logic [7:0]        in_red;
  logic [7:0]        in_green;
  logic [7:0]        in_blue;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] out_slot_address;
  logic [7:0]        out_high_time;
  logic              out_last_word;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_index;
  logic [7:0]        cfg_data;

  grb_word_checker grb_check;
  rx_mode_t        rx_mode = RX_NONE;
  int              rx_run = 0;
  int              cycles = 0;
  int              reg_writes = 0;
  int              settings = 0;
  bit              tx_gapless = 1'b0;

  led_pixel_pulse_encoder_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        grb_check.check_word(out_slot_address, out_high_time, out_last_word);
      end
      if (in_valid && !in_stall) begin
        grb_check.note_pixel(in_led_index, in_red, in_green, in_blue);
      end
      if (cfg_valid && cfg_ready) begin
        grb_check.note_reg_write(cfg_index, cfg_data);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pulse words still due.",
               cycles, grb_check.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (rx_mode)
      RX_NONE:     out_stall <= 1'b0;
      RX_LIGHT:    out_stall <= ($urandom_range(99) < 25);
      RX_HEAVY:    out_stall <= ($urandom_range(99) < 70);
      RX_PERIODIC: out_stall <= ((cycles % 7) < 3);
      RX_LONG: begin
        if (rx_run == 0) begin
          rx_run    <= $urandom_range(30, 1);
          out_stall <= ~out_stall;
        end else begin
          rx_run <= rx_run - 1;
        end
      end
      default:     out_stall <= 1'b0;
    endcase
  end

  task automatic send_pixel(input logic [7:0] led_index, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_led_index <= led_index;
    in_red       <= red;
    in_green     <= green;
    in_blue      <= blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_regs(input logic [7:0] rgb, input logic [7:0] ind, input logic [7:0] one,
                          input logic [7:0] zero, input bit stray);
    write_reg(CFG_RGB_BRIGHTNESS, rgb);
    write_reg(CFG_INDICATOR_BRIGHTNESS, ind);
    write_reg(CFG_ONE_TIME, one);
    write_reg(CFG_ZERO_TIME, zero);
    if (stray) begin
      write_reg(8'($urandom_range(255, int'(CFG_ZERO_TIME) + 1)), 8'($urandom));
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (grb_check.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_index();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return 8'd0;
    if (roll < 85) return 8'($urandom_range(LPE_LED_COUNT - 1, 1));
    return 8'($urandom_range(255, LPE_LED_COUNT));
  endfunction

  function automatic logic [7:0] pick_setting();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'(LPE_INDICATOR_MIN - 1);
      3:       return 8'(LPE_INDICATOR_MIN);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_random_phase(input int items);
    int burst;
    burst = 0;
    for (int n = 0; n < items; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(12, 1);
        if (!tx_gapless) pause_sender($urandom_range(8, 0));
      end
      send_pixel(pick_index(), pick_level(), pick_level(), pick_level());
      burst--;
    end
  endtask

  initial begin
    grb_check    = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_led_index = 8'd0;
    in_red       = 8'd0;
    in_green     = 8'd0;
    in_blue      = 8'd0;
    cfg_valid    = 1'b0;
    cfg_index    = 8'd0;
    cfg_data     = 8'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd1, 8'hFF, 8'h00, 8'h00);
    send_pixel(8'd2, 8'h00, 8'hFF, 8'h00);
    send_pixel(8'd3, 8'h00, 8'h00, 8'hFF);
    send_pixel(8'd15, 8'hAA, 8'h55, 8'hA5);
    send_pixel(8'd15, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd16, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd255, 8'h01, 8'h02, 8'h03);
    send_pixel(8'd7, 8'h00, 8'h00, 8'h00);
    wait_idle();

    set_regs(8'd0, 8'd0, 8'd255, 8'd0, 1'b1);
    rx_mode = RX_LIGHT;
    send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd0, 8'h01, 8'h80, 8'hFE);
    send_pixel(8'd5, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd128, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();

    set_regs(8'd1, 8'(LPE_INDICATOR_MIN - 1), 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'hFF, 8'h80, 8'h7F);
    send_pixel(8'd9, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd14, 8'hFE, 8'hFF, 8'h80);
    wait_idle();
    set_regs(8'd1, 8'(LPE_INDICATOR_MIN), 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    set_regs(8'd1, 8'(LPE_INDICATOR_MIN + 1), 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    set_regs(8'd128, 8'd255, 8'd51, 8'd21, 1'b0);
    send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd12, 8'hFF, 8'h81, 8'h40);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_regs(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
               bit'($urandom_range(1)));
      rx_mode    = rx_mode_t'(ph % 5);
      tx_gapless = ((ph % 3) == 2);
      run_random_phase(ITEMS_PER_PHASE);
      wait_idle();
    end

    $display("Sent %0d pixel words (%0d past the end of the chain) and checked %0d pulse words.",
             grb_check.pixels, grb_check.dropped, grb_check.words_checked);
    $display("Made %0d register writes over %0d brightness and timing settings.",
             reg_writes, settings);
    if (grb_check.errors == 0 && grb_check.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
